### rtl/pinpose_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pinpose_pkg
// Shared types, codes and arithmetic helpers of the pinhole pose projection
// pipeline.
// ----------------------------------------------------------------------------
package pinpose_pkg;

    // Item kinds.
    localparam logic KIND_PROJ = 1'b0;
    localparam logic KIND_BACK = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINC = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT0  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT1  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT2  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TX    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TY    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TZ    = 4'd7;

    // Register reset values.
    localparam logic [47:0] FOCAL_RST = 48'h01F400_01F400;
    localparam logic [47:0] PRINC_RST = 48'h014000_00F000;
    localparam logic [47:0] ROT0_RST  = 48'h4000_0000_0000;
    localparam logic [47:0] ROT1_RST  = 48'h0000_4000_0000;
    localparam logic [47:0] ROT2_RST  = 48'h0000_0000_4000;

    // Divider geometry: 70-bit dividend, 37-bit divisor, 41 quotient bits.
    localparam int DIV_N_W    = 70;
    localparam int DIV_D_W    = 37;
    localparam int DIV_Q_W    = 41;
    localparam int DIV_STAGES = DIV_Q_W + 1;

    // Saturated pixel term and camera coordinate clip.
    localparam logic signed [41:0] PIX_BIG  = 42'sh100_0000_0000;
    localparam logic [39:0]        CAM_CLIP = 40'h7F_FFFF_FFFF;

    typedef struct packed {
        logic zdiv;   // divisor is zero
        logic nz;     // numerator is nonzero
        logic zsign;  // sign used when the divisor is zero
        logic neg;    // sign of the quotient
    } lane_flags_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] depth;
        lane_flags_t [1:0]  lane;
    } side_t;

    // Shift right by 14 with rounding to nearest, halves away from zero.
    function automatic logic signed [63:0] round14(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? (~v + 64'd1) : v;
        m = (m + 64'd8192) >> 14;
        round14 = v[63] ? $signed(~m + 64'd1) : $signed(m);
    endfunction

    // Saturate to 32 bits; bit 32 of the result flags a saturation.
    function automatic logic [32:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) begin
            sat32 = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -48'sd2147483648) begin
            sat32 = {1'b1, 32'h8000_0000};
        end else begin
            sat32 = {1'b0, v[31:0]};
        end
    endfunction

endpackage
`default_nettype wire

### rtl/pinpose_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pinpose_div
// Two-lane pipelined restoring divider, one quotient bit per stage after
// the first, with an overflow check up front and a sideband word per item.
// ----------------------------------------------------------------------------
module pinpose_div
    import pinpose_pkg::*;
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0][DIV_N_W-1:0]         num,
    input  wire logic [1:0][DIV_D_W-1:0]         den,
    input  wire side_t                           side_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0][DIV_Q_W-1:0]              quo,
    output logic [1:0]                           ovf,
    output side_t                                side_out
);

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES:0]   en;
    logic [DIV_STAGES-1:0] v_in;

    logic [DIV_D_W-1:0]   rem_reg  [DIV_STAGES][2];
    logic [DIV_Q_W-1:0]   low_reg  [DIV_STAGES][2];
    logic [DIV_Q_W-1:0]   q_reg    [DIV_STAGES][2];
    logic [DIV_D_W-1:0]   d_reg    [DIV_STAGES][2];
    logic                 ovf_reg  [DIV_STAGES][2];
    side_t                side_reg [DIV_STAGES];

    logic [DIV_D_W-1:0]   rem_next [DIV_STAGES][2];
    logic [DIV_Q_W-1:0]   low_next [DIV_STAGES][2];
    logic [DIV_Q_W-1:0]   q_next   [DIV_STAGES][2];
    logic [DIV_D_W-1:0]   d_next   [DIV_STAGES][2];
    logic                 ovf_next [DIV_STAGES][2];
    side_t                side_next[DIV_STAGES];

    // A stage takes a new transaction when it is empty or its content moves on.
    always_comb
    begin
        en[DIV_STAGES] = out_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            en[k] = ~v_reg[k] | en[k+1];
        end
        v_in = {v_reg[DIV_STAGES-2:0], in_valid};
    end

    assign in_ready = en[0];

    always_comb
    begin
        logic [DIV_D_W:0] rsh;
        logic             ge;
        rsh = '0;
        ge  = 1'b0;
        // The high dividend part must stay below the divisor, otherwise the
        // quotient does not fit in DIV_Q_W bits.
        for (int l = 0; l < 2; l++)
        begin
            rem_next[0][l] = DIV_D_W'(num[l][DIV_N_W-1:DIV_Q_W]);
            low_next[0][l] = num[l][DIV_Q_W-1:0];
            q_next[0][l]   = '0;
            d_next[0][l]   = den[l];
            ovf_next[0][l] = (DIV_D_W'(num[l][DIV_N_W-1:DIV_Q_W]) >= den[l]);
        end
        side_next[0] = side_in;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rsh = {rem_reg[k-1][l], low_reg[k-1][l][DIV_Q_W-1]};
                ge  = (rsh >= {1'b0, d_reg[k-1][l]});
                rem_next[k][l] = ge ? DIV_D_W'(rsh - {1'b0, d_reg[k-1][l]})
                                    : rsh[DIV_D_W-1:0];
                low_next[k][l] = {low_reg[k-1][l][DIV_Q_W-2:0], 1'b0};
                q_next[k][l]   = {q_reg[k-1][l][DIV_Q_W-2:0], ge};
                d_next[k][l]   = d_reg[k-1][l];
                ovf_next[k][l] = ovf_reg[k-1][l];
            end
            side_next[k] = side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (en[k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    low_reg[k][l] <= low_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                    d_reg[k][l]   <= d_next[k][l];
                    ovf_reg[k][l] <= ovf_next[k][l];
                end
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            quo[l] = q_reg[DIV_STAGES-1][l];
            ovf[l] = ovf_reg[DIV_STAGES-1][l];
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/pinhole_pose_projection_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_pose_projection_top
// Pinhole camera with a rigid pose: world point to pixel, and pixel plus
// depth back to a world point, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind, in_x, in_y, in_z. Kind 0
//   projects a world point to a pixel, kind 1 back-projects a pixel and depth.
//   Output channel (out_valid/out_ready) carries out_x, out_y, out_z, status.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no transaction is in flight.
//   From input acceptance to out_valid a transaction passes six front
//   stages, 42 divider stages (the first loads, the others one quotient bit
//   each), four back stages and the output register. Unless a stall holds
//   the flow, one transaction enters per cycle, the two-lane divider's rate.
//   A stalled receiver holds the output register; stages behind it keep
//   filling bubbles, and in_ready drops only when every stage is occupied.
//   Reset empties the pipeline and loads the default pose and intrinsics.
// ----------------------------------------------------------------------------
module pinhole_pose_projection_top
    import pinpose_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 kind,
    input  wire logic signed [31:0]   in_x,
    input  wire logic signed [31:0]   in_y,
    input  wire logic signed [31:0]   in_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        out_x,
    output logic signed [31:0]        out_y,
    output logic signed [31:0]        out_z,
    output logic [1:0]                status,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [47:0]          cfg_data
);

    // Configuration registers and decoded views.
    logic [47:0] focal_reg, princ_reg;
    logic [47:0] rot_reg [3];
    logic [31:0] tx_reg, ty_reg, tz_reg;

    logic [23:0]        foc [2];
    logic [23:0]        pp  [2];
    logic signed [15:0] rot [3][3];
    logic signed [31:0] tr  [3];

    // Pipeline flow control.
    logic [5:0] f_v_reg;
    logic [5:0] en_f;
    logic [3:0] p_v_reg;
    logic [3:0] en_p;
    logic       en_o;
    logic       out_valid_reg;

    // Front stages.
    logic               s1_kind_reg;
    logic signed [33:0] s1_d_reg [3];
    logic signed [33:0] s1_d_next [3];

    logic               s2_kind_reg;
    logic signed [48:0] s2_m_reg [3][3];
    logic [63:0]        s2_prod_reg [2];
    logic [1:0]         s2_bneg_reg;
    logic signed [31:0] s2_depth_reg;
    logic signed [48:0] s2_m_next [3][3];
    logic [63:0]        s2_prod_next [2];
    logic [1:0]         s2_bneg_next;

    logic               s3_kind_reg;
    logic signed [50:0] s3_acc_reg [3];
    logic [63:0]        s3_prod_reg [2];
    logic [1:0]         s3_bneg_reg;
    logic signed [31:0] s3_depth_reg;
    logic signed [50:0] s3_acc_next [3];

    logic               s4_kind_reg;
    logic signed [37:0] s4_pc_reg [3];
    logic [63:0]        s4_prod_reg [2];
    logic [1:0]         s4_bneg_reg;
    logic signed [31:0] s4_depth_reg;
    logic signed [37:0] s4_pc_next [3];

    logic                   s5_kind_reg;
    logic [36:0]            s5_mag_reg [2];
    logic [36:0]            s5_dz_reg;
    lane_flags_t [1:0]      s5_lane_reg;
    logic [63:0]            s5_prod_reg [2];
    logic signed [31:0]     s5_depth_reg;
    logic [36:0]            s5_mag_next [2];
    logic [36:0]            s5_dz_next;
    lane_flags_t [1:0]      s5_lane_next;

    side_t                      s6_side_reg;
    logic [1:0][DIV_N_W-1:0]    s6_num_reg;
    logic [1:0][DIV_D_W-1:0]    s6_den_reg;
    logic [1:0][DIV_N_W-1:0]    s6_num_next;
    logic [1:0][DIV_D_W-1:0]    s6_den_next;

    // Divider outputs.
    logic                       dv_in_ready;
    logic                       dv_valid;
    logic [1:0][DIV_Q_W-1:0]    dv_q;
    logic [1:0]                 dv_ovf;
    side_t                      dv_side;

    // Back stages.
    logic               p1_kind_reg, p1_zero_reg, p1_sat_reg;
    logic signed [41:0] p1_val_reg [2];
    logic signed [31:0] p1_depth_reg;
    logic               p1_zero_next, p1_sat_next;
    logic signed [41:0] p1_val_next [2];

    logic               p2_kind_reg, p2_zero_reg, p2_sat_reg;
    logic [31:0]        p2_res_reg [2];
    logic signed [55:0] p2_bm_reg [3][3];
    logic               p2_sat_next;
    logic [31:0]        p2_res_next [2];
    logic signed [55:0] p2_bm_next [3][3];

    logic               p3_kind_reg, p3_zero_reg, p3_sat_reg;
    logic [31:0]        p3_res_reg [2];
    logic signed [57:0] p3_bacc_reg [3];
    logic signed [57:0] p3_bacc_next [3];

    logic               p4_kind_reg, p4_zero_reg, p4_sat_reg;
    logic [31:0]        p4_res_reg [2];
    logic signed [43:0] p4_br_reg [3];
    logic signed [43:0] p4_br_next [3];

    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] out_x_next, out_y_next, out_z_next;
    logic [1:0]         status_next;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg  <= FOCAL_RST;
            princ_reg  <= PRINC_RST;
            rot_reg[0] <= ROT0_RST;
            rot_reg[1] <= ROT1_RST;
            rot_reg[2] <= ROT2_RST;
            tx_reg     <= '0;
            ty_reg     <= '0;
            tz_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FOCAL: focal_reg  <= cfg_data;
                CFG_PRINC: princ_reg  <= cfg_data;
                CFG_ROT0:  rot_reg[0] <= cfg_data;
                CFG_ROT1:  rot_reg[1] <= cfg_data;
                CFG_ROT2:  rot_reg[2] <= cfg_data;
                CFG_TX:    tx_reg     <= cfg_data[31:0];
                CFG_TY:    ty_reg     <= cfg_data[31:0];
                CFG_TZ:    tz_reg     <= cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        foc[0] = focal_reg[47:24];
        foc[1] = focal_reg[23:0];
        pp[0]  = princ_reg[47:24];
        pp[1]  = princ_reg[23:0];
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rot[r][c] = rot_reg[r][(32 - 16 * c) +: 16];
            end
        end
        tr[0] = tx_reg;
        tr[1] = ty_reg;
        tr[2] = tz_reg;
    end

    // ------------------------------------------------------------------
    // Flow control: each stage loads when empty or when it drains.
    // ------------------------------------------------------------------
    always_comb
    begin
        en_o    = ~out_valid_reg | out_ready;
        en_p[3] = ~p_v_reg[3] | en_o;
        for (int k = 2; k >= 0; k--)
        begin
            en_p[k] = ~p_v_reg[k] | en_p[k+1];
        end
        en_f[5] = ~f_v_reg[5] | dv_in_ready;
        for (int k = 4; k >= 0; k--)
        begin
            en_f[k] = ~f_v_reg[k] | en_f[k+1];
        end
    end

    assign in_ready = en_f[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg       <= '0;
            p_v_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (en_f[k])
                begin
                    f_v_reg[k] <= (k == 0) ? in_valid : f_v_reg[(k == 0) ? 0 : k - 1];
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                if (en_p[k])
                begin
                    p_v_reg[k] <= (k == 0) ? dv_valid : p_v_reg[(k == 0) ? 0 : k - 1];
                end
            end
            if (en_o)
            begin
                out_valid_reg <= p_v_reg[3];
            end
        end
    end

    // ------------------------------------------------------------------
    // Front datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [33:0] a [3];
        logic [36:0] m [3];

        // Stage 1: offsets from the camera center or the principal point.
        // A pixel minus a large principal point needs 34 bits.
        if (kind == KIND_BACK)
        begin
            s1_d_next[0] = {{2{in_x[31]}}, in_x} - {2'b0, pp[0], 8'b0};
            s1_d_next[1] = {{2{in_y[31]}}, in_y} - {2'b0, pp[1], 8'b0};
            s1_d_next[2] = {{2{in_z[31]}}, in_z};
        end
        else
        begin
            s1_d_next[0] = {{2{in_x[31]}}, in_x} - {{2{tr[0][31]}}, tr[0]};
            s1_d_next[1] = {{2{in_y[31]}}, in_y} - {{2{tr[1][31]}}, tr[1]};
            s1_d_next[2] = {{2{in_z[31]}}, in_z} - {{2{tr[2][31]}}, tr[2]};
        end

        // Stage 2: rotation products and back-projection magnitudes.
        for (int i = 0; i < 3; i++)
        begin
            a[i] = s1_d_reg[i][33] ? (34'd0 - s1_d_reg[i]) : s1_d_reg[i];
            for (int j = 0; j < 3; j++)
            begin
                s2_m_next[i][j] = 49'(rot[j][i]) * 49'(s1_d_reg[j]);
            end
        end
        for (int l = 0; l < 2; l++)
        begin
            s2_prod_next[l] = 64'(a[l]) * 64'(a[2][31:0]);
            s2_bneg_next[l] = s1_d_reg[l][33] ^ s1_d_reg[2][33];
        end

        // Stage 3 and 4: camera coordinates.
        for (int i = 0; i < 3; i++)
        begin
            s3_acc_next[i] = 51'(s2_m_reg[i][0]) + 51'(s2_m_reg[i][1])
                           + 51'(s2_m_reg[i][2]);
            s4_pc_next[i]  = 38'(round14(64'(s3_acc_reg[i])));
        end

        // Stage 5: magnitudes and per-lane sign and special-case flags.
        for (int i = 0; i < 3; i++)
        begin
            m[i] = s4_pc_reg[i][37] ? 37'(38'd0 - s4_pc_reg[i]) : s4_pc_reg[i][36:0];
        end
        s5_dz_next = m[2];
        for (int l = 0; l < 2; l++)
        begin
            s5_mag_next[l] = m[l];
            if (s4_kind_reg == KIND_BACK)
            begin
                s5_lane_next[l].zdiv  = (foc[l] == 24'd0);
                s5_lane_next[l].nz    = |s4_prod_reg[l];
                s5_lane_next[l].zsign = s4_bneg_reg[l];
                s5_lane_next[l].neg   = s4_bneg_reg[l];
            end
            else
            begin
                s5_lane_next[l].zdiv  = (m[2] == 37'd0);
                s5_lane_next[l].nz    = |s4_pc_reg[l];
                s5_lane_next[l].zsign = s4_pc_reg[l][37];
                s5_lane_next[l].neg   = s4_pc_reg[l][37] ^ s4_pc_reg[2][37];
            end
        end

        // Stage 6: dividend and divisor. The projection quotient carries one
        // extra fraction bit, the back-projection quotient one as well, so a
        // final add and shift rounds both.
        for (int l = 0; l < 2; l++)
        begin
            if (s5_kind_reg == KIND_BACK)
            begin
                s6_num_next[l] = {5'b0, s5_prod_reg[l], 1'b0};
                s6_den_next[l] = {5'b0, foc[l], 8'b0};
            end
            else
            begin
                s6_num_next[l] = {61'(foc[l]) * 61'(s5_mag_reg[l]), 9'b0};
                s6_den_next[l] = s5_dz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f[0])
        begin
            s1_kind_reg <= kind;
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i] <= s1_d_next[i];
            end
        end
        if (en_f[1])
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_m_reg     <= s2_m_next;
            s2_prod_reg  <= s2_prod_next;
            s2_bneg_reg  <= s2_bneg_next;
            s2_depth_reg <= s1_d_reg[2][31:0];
        end
        if (en_f[2])
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_acc_reg   <= s3_acc_next;
            s3_prod_reg  <= s2_prod_reg;
            s3_bneg_reg  <= s2_bneg_reg;
            s3_depth_reg <= s2_depth_reg;
        end
        if (en_f[3])
        begin
            s4_kind_reg  <= s3_kind_reg;
            s4_pc_reg    <= s4_pc_next;
            s4_prod_reg  <= s3_prod_reg;
            s4_bneg_reg  <= s3_bneg_reg;
            s4_depth_reg <= s3_depth_reg;
        end
        if (en_f[4])
        begin
            s5_kind_reg  <= s4_kind_reg;
            s5_mag_reg   <= s5_mag_next;
            s5_dz_reg    <= s5_dz_next;
            s5_lane_reg  <= s5_lane_next;
            s5_prod_reg  <= s4_prod_reg;
            s5_depth_reg <= s4_depth_reg;
        end
        if (en_f[5])
        begin
            s6_side_reg.kind  <= s5_kind_reg;
            s6_side_reg.depth <= s5_depth_reg;
            s6_side_reg.lane  <= s5_lane_reg;
            s6_num_reg        <= s6_num_next;
            s6_den_reg        <= s6_den_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    pinpose_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_v_reg[5]),
        .in_ready  (dv_in_ready),
        .num       (s6_num_reg),
        .den       (s6_den_reg),
        .side_in   (s6_side_reg),
        .out_valid (dv_valid),
        .out_ready (en_p[0]),
        .quo       (dv_q),
        .ovf       (dv_ovf),
        .side_out  (dv_side)
    );

    // ------------------------------------------------------------------
    // Back datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [DIV_Q_W-1:0] r;
        logic signed [41:0] term;
        logic [39:0]        qb;
        logic               clip;
        logic [32:0]        s;
        logic signed [39:0] pcv [3];

        r    = '0;
        term = '0;
        qb   = '0;
        clip = 1'b0;
        s    = '0;

        // Stage p1: round the quotient and resolve the special cases.
        p1_zero_next = dv_side.lane[0].zdiv | dv_side.lane[1].zdiv;
        p1_sat_next  = 1'b0;
        for (int l = 0; l < 2; l++)
        begin
            r = DIV_Q_W'((42'(dv_q[l]) + 42'd1) >> 1);
            if (dv_side.kind == KIND_BACK)
            begin
                clip = 1'b0;
                if (dv_side.lane[l].zdiv)
                begin
                    qb = dv_side.lane[l].nz ? CAM_CLIP : 40'd0;
                end
                else if (dv_ovf[l] || (r > DIV_Q_W'(CAM_CLIP)))
                begin
                    qb   = CAM_CLIP;
                    clip = 1'b1;
                end
                else
                begin
                    qb = r[39:0];
                end
                p1_sat_next    = p1_sat_next | clip;
                p1_val_next[l] = dv_side.lane[l].neg ? -$signed(42'(qb)) : $signed(42'(qb));
            end
            else
            begin
                if (dv_side.lane[l].zdiv)
                begin
                    if (!dv_side.lane[l].nz)
                    begin
                        term = '0;
                    end
                    else
                    begin
                        term = dv_side.lane[l].zsign ? -PIX_BIG : PIX_BIG;
                    end
                end
                else if (dv_ovf[l])
                begin
                    term = dv_side.lane[l].neg ? -PIX_BIG : PIX_BIG;
                end
                else
                begin
                    term = dv_side.lane[l].neg ? -$signed(42'(r)) : $signed(42'(r));
                end
                p1_val_next[l] = term;
            end
        end

        // Stage p2: pixel offset and saturation, or the rotation products.
        p2_sat_next = p1_sat_reg;
        for (int l = 0; l < 2; l++)
        begin
            s = sat32(48'(p1_val_reg[l]) + {16'b0, pp[l], 8'b0});
            p2_res_next[l] = s[31:0];
            if (p1_kind_reg == KIND_PROJ)
            begin
                p2_sat_next = p2_sat_next | s[32];
            end
        end
        pcv[0] = p1_val_reg[0][39:0];
        pcv[1] = p1_val_reg[1][39:0];
        pcv[2] = 40'(p1_depth_reg);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p2_bm_next[i][j] = 56'(rot[i][j]) * 56'(pcv[j]);
            end
        end

        // Stage p3 and p4: world coordinates before translation.
        for (int i = 0; i < 3; i++)
        begin
            p3_bacc_next[i] = 58'(p2_bm_reg[i][0]) + 58'(p2_bm_reg[i][1])
                            + 58'(p2_bm_reg[i][2]);
            p4_br_next[i]   = 44'(round14(64'(p3_bacc_reg[i])));
        end

        // Output stage: translation and saturation for back-projection.
        status_next = ST_OK;
        if (p4_kind_reg == KIND_BACK)
        begin
            clip = p4_sat_reg;
            s = sat32(48'(p4_br_reg[0]) + 48'(tr[0]));
            out_x_next = s[31:0];
            clip = clip | s[32];
            s = sat32(48'(p4_br_reg[1]) + 48'(tr[1]));
            out_y_next = s[31:0];
            clip = clip | s[32];
            s = sat32(48'(p4_br_reg[2]) + 48'(tr[2]));
            out_z_next = s[31:0];
            clip = clip | s[32];
        end
        else
        begin
            clip       = p4_sat_reg;
            out_x_next = p4_res_reg[0];
            out_y_next = p4_res_reg[1];
            out_z_next = '0;
        end
        if (p4_zero_reg)
        begin
            status_next = ST_ZERO;
        end
        else if (clip)
        begin
            status_next = ST_SAT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_p[0])
        begin
            p1_kind_reg  <= dv_side.kind;
            p1_zero_reg  <= p1_zero_next;
            p1_sat_reg   <= p1_sat_next;
            p1_val_reg   <= p1_val_next;
            p1_depth_reg <= dv_side.depth;
        end
        if (en_p[1])
        begin
            p2_kind_reg <= p1_kind_reg;
            p2_zero_reg <= p1_zero_reg;
            p2_sat_reg  <= p2_sat_next;
            p2_res_reg  <= p2_res_next;
            p2_bm_reg   <= p2_bm_next;
        end
        if (en_p[2])
        begin
            p3_kind_reg <= p2_kind_reg;
            p3_zero_reg <= p2_zero_reg;
            p3_sat_reg  <= p2_sat_reg;
            p3_res_reg  <= p2_res_reg;
            p3_bacc_reg <= p3_bacc_next;
        end
        if (en_p[3])
        begin
            p4_kind_reg <= p3_kind_reg;
            p4_zero_reg <= p3_zero_reg;
            p4_sat_reg  <= p3_sat_reg;
            p4_res_reg  <= p3_res_reg;
            p4_br_reg   <= p4_br_next;
        end
        if (en_o)
        begin
            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_z_reg  <= out_z_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire
